>>> rtl/rta_pkg.sv
// Shared types and codes for the route table block.
`timescale 1ns / 1ps

package rta_pkg;

  // Action codes carried in the request transaction.
  typedef enum logic [1:0] {
    ACT_ADD           = 2'd0,
    ACT_REMOVE_KEY    = 2'd1,
    ACT_REMOVE_SOURCE = 2'd2
  } rta_action_t;

  // Status codes carried in the response transaction.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int RoutesHeldW = 7;

  // One request transaction.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] network;
    logic [5:0]  prefix_length;
    logic [31:0] net_mask;
    logic [31:0] gateway;
    logic [15:0] route_metric;
    logic [1:0]  source;
  } rta_req_t;

  // One response transaction.
  typedef struct packed {
    logic                   status;
    logic [RoutesHeldW-1:0] routes_held;
  } rta_rsp_t;

  // One stored route, as held in the table memory.
  typedef struct packed {
    logic [31:0] network;
    logic [5:0]  prefix_length;
    logic [31:0] net_mask;
    logic [31:0] gateway;
    logic [15:0] route_metric;
    logic [1:0]  source;
  } rta_entry_t;

  localparam int EntryW = $bits(rta_entry_t);

endpackage

>>> rtl/rta_req_if.sv
// Valid/ready channel that carries request transactions.
`timescale 1ns / 1ps

interface rta_req_if;
  logic              valid;
  logic              ready;
  rta_pkg::rta_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rta_rsp_if.sv
// Valid/ready channel that carries response transactions.
`timescale 1ns / 1ps

interface rta_rsp_if;
  logic              valid;
  logic              ready;
  rta_pkg::rta_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/route_table_add_remove_top.sv
// Top level of the route table: add, remove by key and remove by source.
`timescale 1ns / 1ps

// The block keeps an unordered table of up to TABLE_DEPTH routes in one RAM
// and takes one request at a time; each request yields one response. An
// add writes its route if there is room and goes straight to the result
// state. A remove by key reads one entry per cycle through the RAM read
// port; on a hit the last route is copied into the freed slot. A remove by
// source streams the table through the RAM, one entry per cycle, writing
// kept routes down in order. An empty table or an unknown action goes
// straight to the result state. Requests are taken only while no request
// is in progress; a response waiting in the output register does not block
// the next request. No clearing pass is run after reset: only entries below
// the route count are ever read.
module route_table_add_remove_top #(
  parameter int TABLE_DEPTH = 64
) (
  input logic     clk,
  input logic     rst,
  rta_req_if.sink   req,
  rta_rsp_if.source rsp
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY_SCAN,
    S_KEY_MOVE,
    S_SRC_SCAN,
    S_RESULT
  } state_t;

  state_t            state, state_next;
  logic [CntW-1:0]   count, count_next;
  logic [CntW-1:0]   kept, kept_next;
  logic [IdxW-1:0]   rd_idx, rd_idx_next;
  logic [IdxW-1:0]   hit_idx, hit_idx_next;
  logic              status, status_next;
  rta_pkg::rta_req_t cmd;
  logic              out_valid;
  rta_pkg::rta_rsp_t out_data;
  logic              out_load;

  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  rta_pkg::rta_entry_t      wr_data;
  logic                     rd_en;
  logic [IdxW-1:0]          rd_addr;
  logic [rta_pkg::EntryW-1:0] rd_raw;
  rta_pkg::rta_entry_t      rd_data;

  logic            accept;
  logic [IdxW-1:0] last_idx;
  logic            at_last;
  logic            key_hit;
  logic            src_keep;

  rta_ram #(
    .WIDTH(rta_pkg::EntryW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign rd_data   = rd_raw;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Helpers for the scans: last held slot and match tests on read data.
  assign last_idx = IdxW'(count - CntW'(1));
  assign at_last  = (CntW'(rd_idx) + CntW'(1)) == count;
  assign key_hit  = (rd_data.network == cmd.network) &&
                    (rd_data.prefix_length == cmd.prefix_length) &&
                    (rd_data.net_mask == cmd.net_mask);
  assign src_keep = (rd_data.source != cmd.source);

  // Next-state logic and RAM access control.
  always_comb begin
    state_next   = state;
    count_next   = count;
    kept_next    = kept;
    rd_idx_next  = rd_idx;
    hit_idx_next = hit_idx;
    status_next  = status;
    out_load     = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = rd_idx;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = rd_idx + IdxW'(1);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.data.action)
            rta_pkg::ACT_ADD: begin
              if (count < CntW'(TABLE_DEPTH)) begin
                wr_en                 = 1'b1;
                wr_addr               = IdxW'(count);
                wr_data.network       = req.data.network;
                wr_data.prefix_length = req.data.prefix_length;
                wr_data.net_mask      = req.data.net_mask;
                wr_data.gateway       = req.data.gateway;
                wr_data.route_metric  = req.data.route_metric;
                wr_data.source        = req.data.source;
                count_next            = count + CntW'(1);
                status_next           = rta_pkg::STATUS_OK;
              end else begin
                status_next = rta_pkg::STATUS_FAIL;
              end
              state_next = S_RESULT;
            end
            rta_pkg::ACT_REMOVE_KEY: begin
              if (count == '0) begin
                status_next = rta_pkg::STATUS_FAIL;
                state_next  = S_RESULT;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                rd_idx_next = '0;
                state_next  = S_KEY_SCAN;
              end
            end
            rta_pkg::ACT_REMOVE_SOURCE: begin
              status_next = rta_pkg::STATUS_OK;
              if (count == '0) begin
                state_next = S_RESULT;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                rd_idx_next = '0;
                kept_next   = '0;
                state_next  = S_SRC_SCAN;
              end
            end
            default: begin
              status_next = rta_pkg::STATUS_FAIL;
              state_next  = S_RESULT;
            end
          endcase
        end
      end

      // Compare the entry read last cycle; fetch the last route on a hit.
      S_KEY_SCAN: begin
        if (key_hit) begin
          rd_en        = 1'b1;
          rd_addr      = last_idx;
          hit_idx_next = rd_idx;
          state_next   = S_KEY_MOVE;
        end else if (at_last) begin
          status_next = rta_pkg::STATUS_FAIL;
          state_next  = S_RESULT;
        end else begin
          rd_en       = 1'b1;
          rd_idx_next = rd_idx + IdxW'(1);
        end
      end

      // Move the last route into the freed slot.
      S_KEY_MOVE: begin
        wr_en       = 1'b1;
        wr_addr     = hit_idx;
        wr_data     = rd_data;
        count_next  = count - CntW'(1);
        status_next = rta_pkg::STATUS_OK;
        state_next  = S_RESULT;
      end

      // Stream entries and write kept ones down to the kept position.
      S_SRC_SCAN: begin
        if (src_keep) begin
          kept_next = kept + CntW'(1);
          if (kept != CntW'(rd_idx)) begin
            wr_en   = 1'b1;
            wr_addr = IdxW'(kept);
            wr_data = rd_data;
          end
        end
        if (at_last) begin
          count_next = kept_next;
          state_next = S_RESULT;
        end else begin
          rd_en       = 1'b1;
          rd_idx_next = rd_idx + IdxW'(1);
        end
      end

      // Hand the response to the output register once it is free.
      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, route count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and payload; no reset needed.
  always_ff @(posedge clk) begin
    kept    <= kept_next;
    rd_idx  <= rd_idx_next;
    hit_idx <= hit_idx_next;
    status  <= status_next;
    if (accept) begin
      cmd <= req.data;
    end
    if (out_load) begin
      out_data.status      <= status;
      out_data.routes_held <= rta_pkg::RoutesHeldW'(count);
    end
  end

  // The route count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TABLE_DEPTH))
    else $error("route count above table depth");

  // A successful remove by key shrinks the table by exactly one route.
  a_key_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == S_KEY_MOVE) |=> (count == $past(count) - CntW'(1)))
    else $error("remove by key did not shrink the table by one");

  // An add to a table with room grows it by exactly one route.
  a_add_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.data.action == rta_pkg::ACT_ADD) && (count < CntW'(TABLE_DEPTH)))
      |=> (count == $past(count) + CntW'(1)))
    else $error("add did not grow the table by one");

  // Compaction never writes at or beyond the slot being read.
  a_src_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRC_SCAN && wr_en) |-> (kept < CntW'(rd_idx)))
    else $error("compaction write overtook the read position");

endmodule
